FILE: rtl/assert_macros.svh
// Assertion macros for the RTL of the masked byte pattern search.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mbps_pkg.sv
// Package with types and constants of the masked byte pattern search.
package mbps_pkg;

  localparam int MAX_PATTERN_BYTES = 16;
  localparam int PAT_BYTES         = 16;
  localparam int LEN_W             = 5;
  localparam int ADDR_W            = 32;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW    = 3'd0,
    REG_PATTERN_HIGH   = 3'd1,
    REG_WILDCARD_MASK  = 3'd2,
    REG_PATTERN_LENGTH = 3'd3,
    REG_SEARCH_BASE    = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] match_address;
  } out_item_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef struct packed {
    logic       used;
    logic       wild;
    logic [7:0] pat_byte;
  } cell_cfg_t;

endpackage

FILE: rtl/masked_byte_pattern_search_top.sv
// Top level of the masked byte pattern search.
//
// Stream bytes enter on the in_ channel, one item per cycle while in_ready
// is high, each with an end-of-stream mark. A row of cells holds the newest
// bytes, and every used cell compares its byte with the pattern byte aligned
// to it in the same cycle. The first full match of a search produces a result
// item with found set and the address of the first matched byte; later items
// of that search give nothing. A search that ends without a match produces
// found clear and a zero address. The end-of-stream item always rearms the
// search. Throughput is one item per cycle while in_ready is high. A result
// enters the output register, or the skid register if that one is occupied,
// so items keep coming in while a result waits; the buffer drops in_ready
// only when both hold a result. Configuration writes on the cfg_ channel are
// always taken; in_ready is low for the cycle after a write while the
// pattern is realigned to the cells. After reset the config registers hold
// their reset values, the window is empty and the pattern is realigned first.
module masked_byte_pattern_search_top #(
  parameter int MAX_PATTERN_BYTES = mbps_pkg::MAX_PATTERN_BYTES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  mbps_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output mbps_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import mbps_pkg::*;

  `include "assert_macros.svh"

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN_BYTES);

  logic [63:0]       pattern_low_r;
  logic [63:0]       pattern_high_r;
  logic [15:0]       wildcard_mask_r;
  logic [LEN_W-1:0]  pattern_length_r;
  logic [ADDR_W-1:0] search_base_r;
  logic              cfg_pend_r;

  logic [LEN_W-1:0]  len_use;
  logic [8*PAT_BYTES-1:0] pat_all;
  cell_cfg_t         cell_cfg_nxt [MAX_PATTERN_BYTES];
  cell_cfg_t         cell_cfg_r   [MAX_PATTERN_BYTES];
  logic [ADDR_W-1:0] base_adj_r;

  logic [ADDR_W-1:0] offset_r;
  logic              done_r;

  logic              in_acc;
  logic              last;
  cell_ctrl_t        ctrl;
  logic [7:0]        cell_byte  [MAX_PATTERN_BYTES];
  logic              cell_valid [MAX_PATTERN_BYTES];
  logic [MAX_PATTERN_BYTES-1:0] cell_ok;
  logic              hit;
  logic              push;
  out_item_t         push_item;
  logic              buf_full;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_low_r    <= '0;
      pattern_high_r   <= '0;
      wildcard_mask_r  <= '0;
      pattern_length_r <= LEN_W'(1);
      search_base_r    <= '0;
      cfg_pend_r       <= 1'b1;
    end else begin
      cfg_pend_r <= cfg_valid;
      if (cfg_valid) begin
        case (cfg_reg_t'(cfg_index))
          REG_PATTERN_LOW:    pattern_low_r    <= cfg_data;
          REG_PATTERN_HIGH:   pattern_high_r   <= cfg_data;
          REG_WILDCARD_MASK:  wildcard_mask_r  <= cfg_data[15:0];
          REG_PATTERN_LENGTH: pattern_length_r <= cfg_data[LEN_W-1:0];
          REG_SEARCH_BASE:    search_base_r    <= cfg_data[ADDR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Pattern alignment: cell k compares with pattern byte len-1-k.
  always_comb begin
    if (pattern_length_r == '0) begin
      len_use = LEN_W'(1);
    end else if (pattern_length_r > MAX_LEN) begin
      len_use = MAX_LEN;
    end else begin
      len_use = pattern_length_r;
    end
  end

  assign pat_all = {pattern_high_r, pattern_low_r};

  always_comb begin
    logic [LEN_W-1:0] idx;
    for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
      idx = len_use - LEN_W'(1) - LEN_W'(k);
      cell_cfg_nxt[k].used     = (LEN_W'(k) < len_use);
      cell_cfg_nxt[k].wild     = wildcard_mask_r[idx[3:0]];
      cell_cfg_nxt[k].pat_byte = pat_all[{idx[3:0], 3'b000} +: 8];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
      cell_cfg_r[k] <= cell_cfg_nxt[k];
    end
    base_adj_r <= search_base_r + ADDR_W'(1) - ADDR_W'(len_use);
  end

  // Search control.
  assign in_ready   = !buf_full && !cfg_pend_r;
  assign in_acc     = in_valid && in_ready;
  assign last       = in_data.end_of_stream;
  assign ctrl.shift = in_acc && !done_r;
  assign ctrl.clear = in_acc && last;

  genvar g;
  generate
    for (g = 0; g < MAX_PATTERN_BYTES; g++) begin : g_cell
      logic [7:0] b_in;
      logic       v_in;
      if (g == 0) begin : g_head
        assign b_in = in_data.data_byte;
        assign v_in = 1'b1;
      end else begin : g_link
        assign b_in = cell_byte[g-1];
        assign v_in = cell_valid[g-1];
      end
      if (g == MAX_PATTERN_BYTES - 1) begin : g_tail
        mbps_cell u_cell (
          .clk       (clk),
          .rst_n     (rst_n),
          .ctrl      (ctrl),
          .cfg       (cell_cfg_r[g]),
          .byte_in   (b_in),
          .valid_in  (v_in),
          .byte_out  (),
          .valid_out (),
          .ok        (cell_ok[g])
        );
        assign cell_byte[g]  = '0;
        assign cell_valid[g] = 1'b0;
      end else begin : g_body
        mbps_cell u_cell (
          .clk       (clk),
          .rst_n     (rst_n),
          .ctrl      (ctrl),
          .cfg       (cell_cfg_r[g]),
          .byte_in   (b_in),
          .valid_in  (v_in),
          .byte_out  (cell_byte[g]),
          .valid_out (cell_valid[g]),
          .ok        (cell_ok[g])
        );
      end
    end
  endgenerate

  assign hit  = ctrl.shift && (&cell_ok);
  assign push = hit || (ctrl.shift && last);

  assign push_item.found         = hit;
  assign push_item.match_address = hit ? (base_adj_r + offset_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
      done_r   <= 1'b0;
    end else if (ctrl.clear) begin
      offset_r <= '0;
      done_r   <= 1'b0;
    end else if (ctrl.shift) begin
      offset_r <= offset_r + ADDR_W'(1);
      done_r   <= hit;
    end
  end

  mbps_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `ASSERT_NEXT(a_done_after_hit, hit && !last, done_r, "search not closed after a match")
  `ASSERT_NEXT(a_rearm_offset, in_acc && last, offset_r == '0 && !done_r, "search not rearmed")
  `ASSERT_SAME(a_notfound_zero, out_valid && !out_data.found, out_data.match_address == '0,
               "not-found item carries an address")
  `ASSERT_SAME(a_ready_when_empty, !out_valid && !cfg_pend_r, in_ready,
               "input stalled with an empty result buffer")

endmodule

FILE: rtl/mbps_cell.sv
// One window cell: holds one stream byte and compares it with its pattern byte.
module mbps_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  mbps_pkg::cell_ctrl_t ctrl,
  input  mbps_pkg::cell_cfg_t  cfg,
  input  logic [7:0]         byte_in,
  input  logic               valid_in,
  output logic [7:0]         byte_out,
  output logic               valid_out,
  output logic               ok
);
  import mbps_pkg::*;

  logic [7:0] byte_r;
  logic       valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctrl.clear) begin
      valid_r <= 1'b0;
    end else if (ctrl.shift) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      byte_r <= byte_in;
    end
  end

  // The comparison looks at the byte this cell holds once the shift is done.
  assign ok        = !cfg.used || (valid_in && (cfg.wild || (byte_in == cfg.pat_byte)));
  assign byte_out  = byte_r;
  assign valid_out = valid_r;

endmodule

FILE: rtl/mbps_out_buf.sv
// Two-entry result buffer: output register plus skid register.
module mbps_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mbps_pkg::out_item_t push_item,
  output logic                full,
  output logic                out_valid,
  input  logic                out_ready,
  output mbps_pkg::out_item_t out_data
);
  import mbps_pkg::*;

  out_item_t out_item_r, out_item_nxt;
  out_item_t skid_item_r, skid_item_nxt;
  logic      out_valid_r, out_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  logic      pop;

  assign pop = out_valid_r && out_ready;

  always_comb begin
    out_item_nxt   = out_item_r;
    skid_item_nxt  = skid_item_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_item_nxt   = skid_item_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_item_nxt  = push_item;
        out_valid_nxt = 1'b1;
      end else begin
        skid_item_nxt  = push_item;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r  <= out_item_nxt;
    skid_item_r <= skid_item_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule
